// ===== rtl/core/rpk_pkg.sv =====
// Package: shared types, control word format and microprogram of the shuffle block.
`timescale 1ns / 1ps

package rpk_pkg;

  localparam int WORD_W  = 31;
  localparam int FIELD_W = 5;
  localparam int STEP_W  = 3;

  typedef logic [STEP_W-1:0] step_t;

  // Datapath operation selected by the current control word.
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DIV,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_EMIT
  } op_t;

  // Branch condition tested by the sequencer.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_DIV_DONE,
    C_SCAN_HIT,
    C_OUT_ROOM
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jmp_true;
    step_t jmp_false;
  } uword_t;

  // Status flags from datapath to sequencer.
  typedef struct packed {
    logic in_valid;
    logic div_done;
    logic scan_hit;
    logic out_room;
  } status_t;

  localparam step_t S_WAIT      = 3'd0;
  localparam step_t S_DIV       = 3'd1;
  localparam step_t S_SCAN_INIT = 3'd2;
  localparam step_t S_SCAN      = 3'd3;
  localparam step_t S_EMIT      = 3'd4;

  // Microprogram read-only table.
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    begin
      case (step)
        S_WAIT:      w = '{op: OP_LOAD,      cond: C_IN_VALID, jmp_true: S_DIV,
                           jmp_false: S_WAIT};
        S_DIV:       w = '{op: OP_DIV,       cond: C_DIV_DONE, jmp_true: S_SCAN_INIT,
                           jmp_false: S_DIV};
        S_SCAN_INIT: w = '{op: OP_SCAN_INIT, cond: C_ALWAYS,   jmp_true: S_SCAN,
                           jmp_false: S_SCAN};
        S_SCAN:      w = '{op: OP_SCAN,      cond: C_SCAN_HIT, jmp_true: S_EMIT,
                           jmp_false: S_SCAN};
        S_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_ROOM, jmp_true: S_WAIT,
                           jmp_false: S_EMIT};
        default:     w = '{op: OP_LOAD,      cond: C_ALWAYS,   jmp_true: S_WAIT,
                           jmp_false: S_WAIT};
      endcase
      return w;
    end
  endfunction

endpackage

// ===== rtl/core/rpk_useq.sv =====
// Microcode sequencer: step counter, control table lookup and conditional branch.
`timescale 1ns / 1ps

module rpk_useq
  import rpk_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output op_t     op
);

  step_t  step_r;
  step_t  step_nxt;
  uword_t uw;
  logic   taken;

  always_comb begin
    uw = ucode(step_r);
    case (uw.cond)
      C_ALWAYS:   taken = 1'b1;
      C_IN_VALID: taken = status.in_valid;
      C_DIV_DONE: taken = status.div_done;
      C_SCAN_HIT: taken = status.scan_hit;
      C_OUT_ROOM: taken = status.out_room;
      default:    taken = 1'b1;
    endcase
    step_nxt = taken ? uw.jmp_true : uw.jmp_false;
    op       = uw.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== rtl/core/rpk_dpath.sv =====
// Datapath: restoring remainder unit, free-slot scanner, occupancy state and result register.
`timescale 1ns / 1ps

module rpk_dpath
  import rpk_pkg::*;
#(
  parameter int CELLS = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  op_t                  op,
  output status_t              status,
  input  logic                 in_valid,
  input  logic [WORD_W-1:0]    in_random_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FIELD_W-1:0]   out_slot_index,
  output logic [FIELD_W-1:0]   out_placed_value,
  output logic                 out_last_placement
);

  localparam int RW     = $clog2(CELLS + 1);
  localparam int IW     = $clog2(CELLS);
  localparam int DCW    = $clog2(WORD_W);
  localparam logic [RW-1:0]  CELLS_V  = RW'(CELLS);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(WORD_W - 1);

  logic [CELLS-1:0]  occ_r, occ_nxt;
  logic [RW-1:0]     count_r, count_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [RW-1:0]     div_r, div_nxt;
  logic [DCW-1:0]    dcnt_r, dcnt_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [RW-1:0]     seen_r, seen_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] slot_r, slot_nxt, value_r, value_nxt;
  logic              last_r, last_nxt;

  logic [RW:0]       trial;
  logic [RW:0]       diff;
  logic [RW-1:0]     value_w;
  logic              slot_free;
  logic              emit;

  assign slot_free = ~occ_r[idx_r];
  assign value_w   = count_r + RW'(1);

  always_comb begin
    status.in_valid = in_valid;
    status.div_done = (dcnt_r == DIV_LAST);
    status.scan_hit = slot_free && (seen_r == rem_r);
    status.out_room = !out_valid_r || !out_stall;
  end

  assign emit = (op == OP_EMIT) && status.out_room;

  always_comb begin
    occ_nxt       = occ_r;
    count_nxt     = count_r;
    word_nxt      = word_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    dcnt_nxt      = dcnt_r;
    idx_nxt       = idx_r;
    seen_nxt      = seen_r;
    slot_nxt      = slot_r;
    value_nxt     = value_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    trial         = {rem_r, word_r[WORD_W-1]};
    diff          = trial - {1'b0, div_r};
    case (op)
      OP_LOAD: begin
        if (in_valid) begin
          word_nxt = in_random_word;
          rem_nxt  = '0;
          div_nxt  = CELLS_V - count_r;
          dcnt_nxt = '0;
        end
      end
      OP_DIV: begin
        // one quotient bit per step; keep only the remainder
        word_nxt = {word_r[WORD_W-2:0], 1'b0};
        rem_nxt  = diff[RW] ? trial[RW-1:0] : diff[RW-1:0];
        dcnt_nxt = dcnt_r + DCW'(1);
      end
      OP_SCAN_INIT: begin
        idx_nxt  = '0;
        seen_nxt = '0;
      end
      OP_SCAN: begin
        if (!status.scan_hit) begin
          idx_nxt  = idx_r + IW'(1);
          seen_nxt = seen_r + RW'(slot_free);
        end
      end
      OP_EMIT: begin
        if (emit) begin
          slot_nxt      = FIELD_W'(idx_r);
          value_nxt     = FIELD_W'(value_w);
          last_nxt      = (value_w == CELLS_V);
          out_valid_nxt = 1'b1;
          if (value_w == CELLS_V) begin
            occ_nxt   = '0;
            count_nxt = '0;
          end else begin
            occ_nxt        = occ_r;
            occ_nxt[idx_r] = 1'b1;
            count_nxt      = value_w;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      div_r       <= CELLS_V;
      dcnt_r      <= '0;
      seen_r      <= '0;
      idx_r       <= '0;
    end else begin
      occ_r       <= occ_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
      div_r       <= div_nxt;
      dcnt_r      <= dcnt_nxt;
      seen_r      <= seen_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    slot_r  <= slot_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_slot_index     = slot_r;
  assign out_placed_value   = value_r;
  assign out_last_placement = last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CELLS_V)
    else $error("placement count out of range");

  a_map_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ_r) == int'(count_r))
    else $error("occupancy map disagrees with placement count");

  a_emit_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free)
    else $error("placing into an occupied slot");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_SCAN) |-> (rem_r < div_r))
    else $error("rank not below free-slot count");

endmodule

// ===== rtl/core/random_permutation_kth_free_slot.sv =====
// Top level: original Fisher-Yates strike-out shuffle built on a microcoded sequencer.
`timescale 1ns / 1ps
// Steps per request: remainder steps, one per bit of the word, one scan setup, scan steps up to
//   and including the chosen slot, and one emit.
// Requests are handled one at a time: a new one is taken only at the load step, after the last
//   is emitted; it is taken while a result waits, and emit holds while that result is still stalled.
// Reset (synchronous, rst_n low): all slots free, placement count zero, no result pending.

module random_permutation_kth_free_slot
  import rpk_pkg::*;
#(
  parameter int CELLS = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel: one random word per placement
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [WORD_W-1:0]  in_random_word,
  // result channel: chosen slot and value placed
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] out_slot_index,
  output logic [FIELD_W-1:0] out_placed_value,
  output logic               out_last_placement
);

  op_t     op;
  status_t status;

  // Requests enter only at the load step of the microprogram; hold off otherwise
  // and while reset is applied.
  assign in_stall = !rst_n || (op != OP_LOAD);

  // Sequencer walks the control table; branch on datapath status.
  rpk_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op)
  );

  // Datapath: reduce word modulo free slots, find the free slot of that rank,
  // mark it (clearing all slots on the last placement), and drop the result into the output register.
  rpk_dpath #(
    .CELLS (CELLS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .status             (status),
    .in_valid           (in_valid),
    .in_random_word     (in_random_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_slot_index     (out_slot_index),
    .out_placed_value   (out_placed_value),
    .out_last_placement (out_last_placement)
  );

endmodule

// ===== dv/random_permutation_kth_free_slot_tb.sv =====
// Self-checking testbench for the strike-out shuffle block: directed, random and stall tests.
`timescale 1ns / 1ps

module random_permutation_kth_free_slot_tb
  import rpk_pkg::*;
();

  localparam int CELLS          = 25;
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off to back the block up
  localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before the run is declared hung
  localparam int DRAIN_CYCLES   = 80;    // extra wait after the last expected result, to catch stray results
  localparam int IDLE_PCT       = 18;

  // One expected placement, at the result field widths.
  typedef struct packed {
    logic [FIELD_W-1:0] slot_index;
    logic [FIELD_W-1:0] placed_value;
    logic               last_placement;
  } placement_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [WORD_W-1:0]  in_random_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [FIELD_W-1:0] out_slot_index;
  logic [FIELD_W-1:0] out_placed_value;
  logic               out_last_placement;

  // Shadow of the block's shuffle state, advanced on each accepted request.
  logic [CELLS-1:0]   taken_slots = '0;
  int unsigned        placed_so_far = 0;
  placement_t         placement_q[$];
  placement_t         want;

  // Knobs shared by the test tasks and the driving processes.
  bit                 tx_idle_en = 1'b1;
  bit                 rx_idle_en = 1'b1;
  bit                 hold_req = 1'b0;
  int                 hold_left = 0;

  int                 errors = 0;
  int                 requests_taken = 0;
  int                 results_seen = 0;
  int                 shuffles_done = 0;
  int                 quiet_cycles = 0;

  random_permutation_kth_free_slot #(
    .CELLS(CELLS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_random_word    (in_random_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_slot_index    (out_slot_index),
    .out_placed_value  (out_placed_value),
    .out_last_placement(out_last_placement)
  );

  always #5 clk = ~clk;

  // Predict one placement: reduce the word by the free-slot count, walk the
  // slots in index order counting only free ones, and take the one of that rank.
  // The last placement of a shuffle clears the shadow state for the next one.
  function automatic placement_t place_next(input logic [WORD_W-1:0] word);
    int unsigned free_cnt;
    int unsigned rank;
    int unsigned seen;
    int unsigned pick;
    placement_t  p;
    free_cnt = CELLS - placed_so_far;
    rank     = word % free_cnt;
    seen     = 0;
    pick     = 0;
    for (int j = 0; j < CELLS; j++) begin
      if (!taken_slots[j]) begin
        if (seen == rank) pick = j;
        seen++;
      end
    end
    taken_slots[pick] = 1'b1;
    placed_so_far++;
    p.slot_index     = pick[FIELD_W-1:0];
    p.placed_value   = placed_so_far[FIELD_W-1:0];
    p.last_placement = (placed_so_far == CELLS);
    if (p.last_placement) begin
      taken_slots   = '0;
      placed_so_far = 0;
    end
    return p;
  endfunction

  // Pick a word, biased toward the edges of the range so that the lowest and
  // highest words come up often, not only through uniform chance.
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(9))
      0:       w = WORD_W'($urandom_range(0, 63));
      1:       w = {WORD_W{1'b1}} - WORD_W'($urandom_range(0, 63));
      default: w = WORD_W'($urandom());
    endcase
    return w;
  endfunction

  // Offer one request, with random gaps before it when idling is on, and
  // hold it until the block takes it. Returns just after the accepting edge.
  task automatic send_word(input logic [WORD_W-1:0] word);
    @(negedge clk);
    if (tx_idle_en) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid       = 1'b1;
    in_random_word = word;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Receiver: drop into random stalls, or hold off for a long stretch on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= rx_idle_en && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Record each accepted request before checking results, so that ordering
  // within the edge cannot matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        placement_q.push_back(place_next(in_random_word));
        requests_taken++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (placement_q.size() == 0) begin
          $error("result with no request pending: slot %0d value %0d last %0b",
                 out_slot_index, out_placed_value, out_last_placement);
          errors++;
        end else begin
          want = placement_q.pop_front();
          if (out_slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, out_slot_index);
            errors++;
          end
          if (out_placed_value !== want.placed_value) begin
            $error("placed_value: expected %0d, got %0d",
                   want.placed_value, out_placed_value);
            errors++;
          end
          if (out_last_placement !== want.last_placement) begin
            $error("last_placement: expected %0b, got %0b",
                   want.last_placement, out_last_placement);
            errors++;
          end
          if (want.last_placement) shuffles_done++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("random_permutation_kth_free_slot_tb NOT OK");
      $finish;
    end
  end

  // One full shuffle from reset: zero and all-ones words, then words that land
  // alternately on the highest and lowest free rank, ending on the completing
  // placement where only one slot is left.
  task automatic test_directed_shuffle();
    int unsigned free_cnt;
    logic [WORD_W-1:0] w;
    send_word('0);
    send_word({WORD_W{1'b1}});
    for (int i = 2; i < CELLS - 1; i++) begin
      free_cnt = CELLS - i;
      if (i % 2 == 0) w = WORD_W'(free_cnt - 1 + free_cnt * $urandom_range(0, 1000));
      else            w = WORD_W'(free_cnt * $urandom_range(1, 1000));
      send_word(w);
    end
    send_word({WORD_W{1'b1}});
  endtask

  // Random words with both sides idling at random.
  task automatic test_random_stream(input int count);
    repeat (count) send_word(pick_word());
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_no_idle(input int count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (count) send_word(pick_word());
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Hold the receiver off for a long stretch while requests keep coming, so
  // the block fills and stalls its input.
  task automatic test_output_hold(input int count);
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    repeat (count) send_word(pick_word());
    tx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_directed_shuffle();
    test_random_stream(400);
    test_no_idle(200);
    test_output_hold(30);
    test_random_stream(200);

    // Stop offering, let every expected result arrive, then wait on so that any stray result is caught.
    @(negedge clk);
    in_valid = 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d results, %0d complete shuffles,",
             requests_taken, results_seen, shuffles_done);
    $display("with random idling, a no-idle stretch and a long receiver hold-off.");
    if (errors == 0) begin
      $display("random_permutation_kth_free_slot_tb OK");
    end else begin
      $display("random_permutation_kth_free_slot_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rpk_pkg.sv
rtl/core/rpk_useq.sv
rtl/core/rpk_dpath.sv
rtl/core/random_permutation_kth_free_slot.sv
dv/random_permutation_kth_free_slot_tb.sv
